/* src/lrhc_pkg.sv */
package lrhc_pkg;

  localparam int unsigned WIN_BITS    = 13;
  localparam int unsigned STRIDE_BITS = 16;
  localparam int unsigned BPP_BITS    = 3;
  localparam int unsigned OFFSET_BITS = 28;
  localparam int unsigned COLOR_BITS  = 24;
  localparam int unsigned HEIGHT_BITS = 16;
  localparam int unsigned CFG_BITS    = 16;
  localparam int unsigned RAMP_STEPS  = 9;

  typedef enum logic [1:0] {
    CFG_WINDOW_WIDTH  = 2'd0,
    CFG_WINDOW_HEIGHT = 2'd1,
    CFG_ROW_STRIDE    = 2'd2,
    CFG_BYTES_PER_PIX = 2'd3
  } cfg_index_e;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_type_e;

  localparam logic [WIN_BITS-1:0]    WINDOW_WIDTH_RST  = 13'd1024;
  localparam logic [WIN_BITS-1:0]    WINDOW_HEIGHT_RST = 13'd768;
  localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RST    = 16'd4096;
  localparam logic [BPP_BITS-1:0]    BYTES_PER_PIX_RST = 3'd4;

  typedef logic [COLOR_BITS-1:0] color_t;

  localparam color_t RAMP_COLORS [RAMP_STEPS] = '{
    24'hFFFFFF, 24'h57CAFF, 24'h4EB5E5, 24'h45A1CC, 24'h3C8DB2,
    24'h427999, 24'h2B657F, 24'h225066, 24'h1A3C4C
  };

  // Height class: zero is its own class, below 2 (negatives too) is class 1,
  // then one class per power of two below 128, and 128 and above is class 8.
  function automatic color_t ramp_color(input logic signed [HEIGHT_BITS-1:0] h);
    color_t c;
    c = RAMP_COLORS[8];
    if (h == '0)
      c = RAMP_COLORS[0];
    else if (h < 16'sd2)
      c = RAMP_COLORS[1];
    else if (h < 16'sd4)
      c = RAMP_COLORS[2];
    else if (h < 16'sd8)
      c = RAMP_COLORS[3];
    else if (h < 16'sd16)
      c = RAMP_COLORS[4];
    else if (h < 16'sd32)
      c = RAMP_COLORS[5];
    else if (h < 16'sd64)
      c = RAMP_COLORS[6];
    else if (h < 16'sd128)
      c = RAMP_COLORS[7];
    return c;
  endfunction

endpackage

/* src/line_rasterizer_height_color.sv */
// Channel  Direction  Handshake             Beat contents
// in       input      in_valid_i/in_stall_o  req_type, start/end point, two heights
// out      output     out_valid_o/out_stall_i pixel x/y, byte offset, color, write, last
// cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// One input beat per clock while in_stall_o is low. A step beat's pixel is held in the
// walker's pixel register, then the offset multiply-add fills the output register.
// Loads and steps while idle give no output beat.
// Reset clears the segment state to idle and loads the register defaults.
// in_stall_o rises only while both pipeline registers are full and out_stall_i is high.
module line_rasterizer_height_color #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_index_i,
  input  logic [lrhc_pkg::CFG_BITS-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  req_type_i,
  input  logic signed [COORD_BITS-1:0]          start_x_i,
  input  logic signed [COORD_BITS-1:0]          start_y_i,
  input  logic signed [COORD_BITS-1:0]          end_x_i,
  input  logic signed [COORD_BITS-1:0]          end_y_i,
  input  logic signed [lrhc_pkg::HEIGHT_BITS-1:0] height_here_i,
  input  logic signed [lrhc_pkg::HEIGHT_BITS-1:0] height_next_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [COORD_BITS-1:0]          pixel_x_o,
  output logic signed [COORD_BITS-1:0]          pixel_y_o,
  output logic [lrhc_pkg::OFFSET_BITS-1:0]      byte_offset_o,
  output logic [lrhc_pkg::COLOR_BITS-1:0]       pixel_color_o,
  output logic                                  write_enable_o,
  output logic                                  last_pixel_o
);
  import lrhc_pkg::*;

  localparam int unsigned YPROD_BITS = COORD_BITS + STRIDE_BITS;
  localparam int unsigned XPROD_BITS = COORD_BITS + BPP_BITS;
  localparam int unsigned SUM_BITS   =
    ((YPROD_BITS + 1) > OFFSET_BITS) ? (YPROD_BITS + 1) : OFFSET_BITS;

  logic [WIN_BITS-1:0]    win_w_q, win_h_q;
  logic [STRIDE_BITS-1:0] stride_q;
  logic [BPP_BITS-1:0]    bpp_q;

  logic                         in_accept;
  logic                         s1_valid, s1_inside, s1_last, s1_take;
  logic signed [COORD_BITS-1:0] s1_x, s1_y;
  color_t                       s1_color;

  logic [YPROD_BITS-1:0]  y_prod;
  logic [XPROD_BITS-1:0]  x_prod;
  logic [SUM_BITS-1:0]    off_sum;
  logic [OFFSET_BITS-1:0] offset_d;

  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
  logic [OFFSET_BITS-1:0]       offset_q;
  color_t                       color_q;
  logic                         we_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q  <= WINDOW_WIDTH_RST;
      win_h_q  <= WINDOW_HEIGHT_RST;
      stride_q <= ROW_STRIDE_RST;
      bpp_q    <= BYTES_PER_PIX_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_WINDOW_WIDTH:  win_w_q  <= cfg_data_i[WIN_BITS-1:0];
        CFG_WINDOW_HEIGHT: win_h_q  <= cfg_data_i[WIN_BITS-1:0];
        CFG_ROW_STRIDE:    stride_q <= cfg_data_i[STRIDE_BITS-1:0];
        CFG_BYTES_PER_PIX: bpp_q    <= cfg_data_i[BPP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pixel register moves on when the output register is empty or being drained
  assign s1_take    = s1_valid && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  lrhc_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .req_type_i      (req_type_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .height_here_i   (height_here_i),
    .height_next_i   (height_next_i),
    .window_width_i  (win_w_q),
    .window_height_i (win_h_q),
    .take_i          (s1_take),
    .valid_o         (s1_valid),
    .pix_x_o         (s1_x),
    .pix_y_o         (s1_y),
    .inside_o        (s1_inside),
    .color_o         (s1_color),
    .last_o          (s1_last)
  );

  always_comb begin
    y_prod   = $unsigned(s1_y) * stride_q;
    x_prod   = $unsigned(s1_x) * bpp_q;
    off_sum  = SUM_BITS'(y_prod) + SUM_BITS'(x_prod);
    offset_d = s1_inside ? off_sum[OFFSET_BITS-1:0] : '0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_take)
      out_valid_d = 1'b1;
    else if (!out_stall_i)
      out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      out_valid_q <= 1'b0;
    else
      out_valid_q <= out_valid_d;
  end

  // Hold the beat while stalled
  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      pixel_x_q <= s1_x;
      pixel_y_q <= s1_y;
      offset_q  <= offset_d;
      color_q   <= s1_color;
      we_q      <= s1_inside;
      last_q    <= s1_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = pixel_x_q;
  assign pixel_y_o      = pixel_y_q;
  assign byte_offset_o  = offset_q;
  assign pixel_color_o  = color_q;
  assign write_enable_o = we_q;
  assign last_pixel_o   = last_q;

endmodule

/* src/lrhc_walker.sv */
module lrhc_walker #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic                                  req_type_i,
  input  logic signed [COORD_BITS-1:0]          start_x_i,
  input  logic signed [COORD_BITS-1:0]          start_y_i,
  input  logic signed [COORD_BITS-1:0]          end_x_i,
  input  logic signed [COORD_BITS-1:0]          end_y_i,
  input  logic signed [lrhc_pkg::HEIGHT_BITS-1:0] height_here_i,
  input  logic signed [lrhc_pkg::HEIGHT_BITS-1:0] height_next_i,
  input  logic [lrhc_pkg::WIN_BITS-1:0]         window_width_i,
  input  logic [lrhc_pkg::WIN_BITS-1:0]         window_height_i,
  input  logic                                  take_i,
  output logic                                  valid_o,
  output logic signed [COORD_BITS-1:0]          pix_x_o,
  output logic signed [COORD_BITS-1:0]          pix_y_o,
  output logic                                  inside_o,
  output lrhc_pkg::color_t                      color_o,
  output logic                                  last_o
);
  import lrhc_pkg::*;

  localparam int unsigned SPAN_BITS = COORD_BITS + 1;
  localparam int unsigned ERR_BITS  = COORD_BITS + 2;
  localparam int unsigned CMP_BITS  = ((COORD_BITS > WIN_BITS) ? COORD_BITS : WIN_BITS) + 1;

  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
  logic signed [COORD_BITS-1:0] cur_x_d, cur_y_d, tgt_x_d, tgt_y_d;
  logic [SPAN_BITS-1:0]         span_x_q, span_y_q, span_x_d, span_y_d;
  logic                         dir_x_neg_q, dir_y_neg_q, dir_x_neg_d, dir_y_neg_d;
  logic signed [ERR_BITS-1:0]   err_q, err_d;
  color_t                       seg_color_q, seg_color_d;
  logic                         active_q, active_d;

  logic signed [COORD_BITS-1:0] pix_x_q, pix_y_q;
  logic                         inside_q, last_q, valid_q, valid_d;
  color_t                       color_q;

  logic signed [SPAN_BITS-1:0]  ld_dx, ld_dy;
  logic                         ld_dir_x_neg, ld_dir_y_neg;
  logic [SPAN_BITS-1:0]         ld_span_x, ld_span_y;
  logic signed [HEIGHT_BITS-1:0] h_max;

  logic signed [ERR_BITS-1:0]   spx_s, spy_s;
  logic                         step_x, step_y;
  logic signed [COORD_BITS-1:0] nx, ny;
  logic                         nlast, emit, in_window;

  // Segment setup
  always_comb begin
    ld_dir_x_neg = !(start_x_i < end_x_i);
    ld_dir_y_neg = !(start_y_i < end_y_i);
    ld_dx = ld_dir_x_neg ? (SPAN_BITS'(start_x_i) - SPAN_BITS'(end_x_i))
                         : (SPAN_BITS'(end_x_i) - SPAN_BITS'(start_x_i));
    ld_dy = ld_dir_y_neg ? (SPAN_BITS'(start_y_i) - SPAN_BITS'(end_y_i))
                         : (SPAN_BITS'(end_y_i) - SPAN_BITS'(start_y_i));
    ld_span_x = ld_dx;
    ld_span_y = ld_dy;
    h_max = (height_here_i > height_next_i) ? height_here_i : height_next_i;
  end

  // One Bresenham increment
  always_comb begin
    spx_s  = $signed(ERR_BITS'(span_x_q));
    spy_s  = $signed(ERR_BITS'(span_y_q));
    step_x = err_q > -spx_s;
    step_y = err_q < spy_s;
    nx = cur_x_q;
    ny = cur_y_q;
    if (step_x) begin
      nx = dir_x_neg_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
    end
    if (step_y) begin
      ny = dir_y_neg_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
    end
    nlast = (nx == tgt_x_q) && (ny == tgt_y_q);
    in_window = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1] &&
                (CMP_BITS'($unsigned(cur_x_q)) < CMP_BITS'(window_width_i)) &&
                (CMP_BITS'($unsigned(cur_y_q)) < CMP_BITS'(window_height_i));
  end

  assign emit = accept_i && (req_type_i == REQ_STEP) && active_q;

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    tgt_x_d     = tgt_x_q;
    tgt_y_d     = tgt_y_q;
    span_x_d    = span_x_q;
    span_y_d    = span_y_q;
    dir_x_neg_d = dir_x_neg_q;
    dir_y_neg_d = dir_y_neg_q;
    err_d       = err_q;
    seg_color_d = seg_color_q;
    active_d    = active_q;
    if (accept_i && (req_type_i == REQ_LOAD)) begin
      cur_x_d     = start_x_i;
      cur_y_d     = start_y_i;
      tgt_x_d     = end_x_i;
      tgt_y_d     = end_y_i;
      span_x_d    = ld_span_x;
      span_y_d    = ld_span_y;
      dir_x_neg_d = ld_dir_x_neg;
      dir_y_neg_d = ld_dir_y_neg;
      err_d = (ld_span_x > ld_span_y) ? $signed(ERR_BITS'(ld_span_x >> 1))
                                      : -$signed(ERR_BITS'(ld_span_y >> 1));
      seg_color_d = ramp_color(h_max);
      active_d    = !((start_x_i == end_x_i) && (start_y_i == end_y_i));
    end else if (emit) begin
      cur_x_d  = nx;
      cur_y_d  = ny;
      err_d    = err_q - (step_x ? spy_s : '0) + (step_y ? spx_s : '0);
      active_d = !nlast;
    end
  end

  // Pixel register: fill on emit, drain when the next stage takes it
  always_comb begin
    valid_d = valid_q;
    if (emit)
      valid_d = 1'b1;
    else if (take_i)
      valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      span_x_q    <= '0;
      span_y_q    <= '0;
      dir_x_neg_q <= 1'b0;
      dir_y_neg_q <= 1'b0;
      err_q       <= '0;
      seg_color_q <= '0;
      active_q    <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      tgt_x_q     <= tgt_x_d;
      tgt_y_q     <= tgt_y_d;
      span_x_q    <= span_x_d;
      span_y_q    <= span_y_d;
      dir_x_neg_q <= dir_x_neg_d;
      dir_y_neg_q <= dir_y_neg_d;
      err_q       <= err_d;
      seg_color_q <= seg_color_d;
      active_q    <= active_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pix_x_q  <= cur_x_q;
      pix_y_q  <= cur_y_q;
      inside_q <= in_window;
      color_q  <= seg_color_q;
      last_q   <= nlast;
    end
  end

  assign valid_o  = valid_q;
  assign pix_x_o  = pix_x_q;
  assign pix_y_o  = pix_y_q;
  assign inside_o = inside_q;
  assign color_o  = color_q;
  assign last_o   = last_q;

endmodule

/* bench/line_rasterizer_height_color_test.sv */
module line_rasterizer_height_color_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lrhc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    req_type_e          kind;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic signed [15:0] h0;
    logic signed [15:0] h1;
  } line_req_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [27:0]        offset;
    logic [23:0]        color;
    logic               wr_en;
    logic               is_last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = CFG_WINDOW_WIDTH;
  logic [CFG_BITS-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = REQ_LOAD;
  logic signed [15:0] start_x_i = '0;
  logic signed [15:0] start_y_i = '0;
  logic signed [15:0] end_x_i = '0;
  logic signed [15:0] end_y_i = '0;
  logic signed [15:0] height_here_i = '0;
  logic signed [15:0] height_next_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] pixel_x_o;
  logic signed [15:0] pixel_y_o;
  logic [OFFSET_BITS-1:0] byte_offset_o;
  logic [COLOR_BITS-1:0] pixel_color_o;
  logic write_enable_o;
  logic last_pixel_o;

  line_rasterizer_height_color dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .req_type_i(req_type_i),
    .start_x_i(start_x_i),
    .start_y_i(start_y_i),
    .end_x_i(end_x_i),
    .end_y_i(end_y_i),
    .height_here_i(height_here_i),
    .height_next_i(height_next_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pixel_x_o(pixel_x_o),
    .pixel_y_o(pixel_y_o),
    .byte_offset_o(byte_offset_o),
    .pixel_color_o(pixel_color_o),
    .write_enable_o(write_enable_o),
    .last_pixel_o(last_pixel_o)
  );

  // Register copies
  logic [WIN_BITS-1:0]    win_w  = WINDOW_WIDTH_RST;
  logic [WIN_BITS-1:0]    win_h  = WINDOW_HEIGHT_RST;
  logic [STRIDE_BITS-1:0] stride = ROW_STRIDE_RST;
  logic [BPP_BITS-1:0]    bpp    = BYTES_PER_PIX_RST;

  // Line walker state
  logic signed [15:0] at_x = '0, at_y = '0, to_x = '0, to_y = '0;
  logic [16:0]        run_x = '0, run_y = '0;
  logic               neg_x = 1'b0, neg_y = 1'b0;
  logic signed [17:0] walk_err = '0;
  logic [23:0]        seg_color = '0;
  logic               busy = 1'b0;

  line_req_t   line_requests[$];
  pixel_t      expected_pixels[$];
  line_req_t   cur_req;
  logic        beat_held = 1'b0;
  int unsigned queued_items = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 48;
  logic        long_hold_go = 1'b0;
  logic        long_hold_used = 1'b0;
  int unsigned hold_left = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [23:0] ramp_shade(int h);
    int cls;
    int lim;
    cls = 1;
    lim = 2;
    if (h == 0) return 24'hFFFFFF;
    while (cls < 8 && h >= lim) begin
      lim = lim * 2;
      cls++;
    end
    case (cls)
      1: return 24'h57CAFF;
      2: return 24'h4EB5E5;
      3: return 24'h45A1CC;
      4: return 24'h3C8DB2;
      5: return 24'h427999;
      6: return 24'h2B657F;
      7: return 24'h225066;
      default: return 24'h1A3C4C;
    endcase
  endfunction

  // Apply one accepted beat to the walker; a step on an active line yields a pixel.
  function automatic void walk_segment(line_req_t r);
    pixel_t p;
    int xi, yi, e2;
    longint off;
    logic signed [15:0] hmax;
    if (r.kind == REQ_LOAD) begin
      at_x = r.sx;
      at_y = r.sy;
      to_x = r.ex;
      to_y = r.ey;
      neg_x = !(r.sx < r.ex);
      neg_y = !(r.sy < r.ey);
      run_x = neg_x ? 17'(int'(r.sx) - int'(r.ex)) : 17'(int'(r.ex) - int'(r.sx));
      run_y = neg_y ? 17'(int'(r.sy) - int'(r.ey)) : 17'(int'(r.ey) - int'(r.sy));
      walk_err = (run_x > run_y) ? 18'(int'(run_x) / 2) : 18'(-(int'(run_y) / 2));
      hmax = (r.h0 > r.h1) ? r.h0 : r.h1;
      seg_color = ramp_shade(int'(hmax));
      busy = !(r.sx == r.ex && r.sy == r.ey);
      return;
    end
    if (!busy) return;
    xi = int'(at_x);
    yi = int'(at_y);
    e2 = int'(walk_err);
    p.x = at_x;
    p.y = at_y;
    p.wr_en = xi >= 0 && yi >= 0 && xi < int'(win_w) && yi < int'(win_h);
    off = 0;
    if (p.wr_en) off = longint'(yi) * longint'(stride) + longint'(xi) * longint'(bpp);
    p.offset = off[27:0];
    p.color = seg_color;
    if (e2 > -int'(run_x)) begin
      walk_err = 18'(int'(walk_err) - int'(run_y));
      at_x = neg_x ? at_x - 16'sd1 : at_x + 16'sd1;
    end
    if (e2 < int'(run_y)) begin
      walk_err = 18'(int'(walk_err) + int'(run_x));
      at_y = neg_y ? at_y - 16'sd1 : at_y + 16'sd1;
    end
    p.is_last = (at_x == to_x && at_y == to_y);
    if (p.is_last) busy = 1'b0;
    expected_pixels.push_back(p);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      beat_held = 1'b0;
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        walk_segment(cur_req);
        beat_held = 1'b0;
      end
      // hold a stalled beat; otherwise maybe offer the next one
      if (!beat_held && line_requests.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        cur_req = line_requests.pop_front();
        beat_held = 1'b1;
        req_type_i <= cur_req.kind;
        start_x_i <= cur_req.sx;
        start_y_i <= cur_req.sy;
        end_x_i <= cur_req.ex;
        end_y_i <= cur_req.ey;
        height_here_i <= cur_req.h0;
        height_next_i <= cur_req.h1;
      end
      in_valid_i <= beat_held;
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, got x=%0d y=%0d", $time,
                 pixel_x_o, pixel_y_o);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_x", want.x, pixel_x_o);
        check_field("pixel_y", want.y, pixel_y_o);
        check_field("byte_offset", want.offset, byte_offset_o);
        check_field("pixel_color", want.color, pixel_color_o);
        check_field("write_enable", want.wr_en, write_enable_o);
        check_field("last_pixel", want.is_last, last_pixel_o);
      end
    end
    if (long_hold_go && !long_hold_used) begin
      long_hold_used = 1'b1;
      hold_left = 120;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  function automatic line_req_t random_req(req_type_e kind);
    line_req_t r;
    r.kind = kind;
    r.sx = 16'($urandom);
    r.sy = 16'($urandom);
    r.ex = 16'($urandom);
    r.ey = 16'($urandom);
    r.h0 = 16'($urandom);
    r.h1 = 16'($urandom);
    return r;
  endfunction

  function automatic line_req_t make_load(int sx, int sy, int ex, int ey, int h0, int h1);
    line_req_t r;
    r = random_req(REQ_LOAD);
    r.sx = 16'(sx);
    r.sy = 16'(sy);
    r.ex = 16'(ex);
    r.ey = 16'(ey);
    r.h0 = 16'(h0);
    r.h1 = 16'(h1);
    return r;
  endfunction

  // Mostly near the origin, some around the window edge, a few anywhere.
  function automatic logic signed [15:0] pick_coord(logic [WIN_BITS-1:0] lim);
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 6) return 16'(int'($urandom_range(40)) - 8);
    if (sel < 9) return 16'(int'(lim) + int'($urandom_range(8)) - 4);
    return 16'($urandom);
  endfunction

  task automatic push_req(line_req_t r);
    line_requests.push_back(r);
    queued_items++;
  endtask

  task automatic push_steps(int n);
    repeat (n) push_req(random_req(REQ_STEP));
  endtask

  task automatic queue_segment();
    line_req_t r;
    int dx, dy, span, n;
    r = random_req(REQ_LOAD);
    r.sx = pick_coord(win_w);
    r.sy = pick_coord(win_h);
    r.ex = pick_coord(win_w);
    r.ey = pick_coord(win_h);
    if ($urandom_range(19) == 0) begin
      r.ex = r.sx;
      r.ey = r.sy;
    end
    if ($urandom_range(1) == 0) begin
      r.h0 = 16'(int'($urandom_range(300)) - 40);
      r.h1 = 16'(int'($urandom_range(300)) - 40);
    end
    dx = int'(r.ex) - int'(r.sx);
    dy = int'(r.ey) - int'(r.sy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    span = (dx > dy) ? dx : dy;
    n = (span > 40) ? int'($urandom_range(40, 5)) : span + int'($urandom_range(2));
    // cut some lines short so the next load replaces them
    if ($urandom_range(11) == 0) n = $urandom_range((span > 3) ? 3 : span);
    push_req(r);
    push_steps(n);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    stop_at = queued_items + count;
    while (queued_items < stop_at) queue_segment();
  endtask

  task automatic drain();
    while (line_requests.size() != 0 || beat_held || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [CFG_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_WINDOW_WIDTH:  win_w = data[WIN_BITS-1:0];
      CFG_WINDOW_HEIGHT: win_h = data[WIN_BITS-1:0];
      CFG_ROW_STRIDE:    stride = data[STRIDE_BITS-1:0];
      CFG_BYTES_PER_PIX: bpp = data[BPP_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_window(int w, int h, int s, int b);
    write_reg(CFG_WINDOW_WIDTH, CFG_BITS'(w));
    write_reg(CFG_WINDOW_HEIGHT, CFG_BITS'(h));
    write_reg(CFG_ROW_STRIDE, CFG_BITS'(s));
    write_reg(CFG_BYTES_PER_PIX, CFG_BITS'(b));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines on the reset window
    push_steps(1);
    push_req(make_load(7, 7, 7, 7, 0, 0));
    push_steps(1);
    push_req(make_load(0, 0, 3, 0, 0, 0));
    push_steps(4);
    push_req(make_load(5, 5, 3, 1, -1, 1));
    push_steps(4);
    push_req(make_load(-32768, -32768, 32767, 32767, 32767, -32768));
    push_steps(2);
    push_req(make_load(1023, 767, 1025, 770, 200, -5));
    push_steps(4);
    push_req(make_load(-2, 1, 1, -1, -32768, -32768));
    push_steps(3);
    drain();

    set_window(64, 48, 256, 4);
    // pause the sender mid-line until every pixel is back, then resume the line
    push_req(make_load(0, 0, 30, 7, 9, 3));
    push_steps(5);
    drain();
    push_steps(10);
    run_random(130);
    drain();

    send_idle_pct = 48;
    recv_idle_pct = 32;
    set_window(1, 1, 1, 1);
    run_random(90);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_window(4096, 4096, 65535, 7);
    // long receiver hold while a long line keeps the input busy
    long_hold_go = 1'b1;
    push_req(make_load(0, 0, 200, 50, 100, 60));
    push_steps(40);
    run_random(70);
    drain();

    // offsets wrap past 28 bits here
    set_window(8191, 8191, 65535, 0);
    run_random(70);
    drain();

    set_window(0, 0, 0, 2);
    run_random(40);
    drain();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
